/* rtl/core/ftp_pkg.sv */
// shared types, constants and register codes for the fixed timestep pacer
// no dependencies; imported by the interfaces and every module of the block
package ftp_pkg;

  localparam int unsigned DATA_W      = 32;  // q8.24 time words and counters
  localparam int unsigned SCALE_W     = 16;  // q8.8 time scale
  localparam int unsigned FRAC_W      = 16;  // q0.16 blend fraction
  localparam int unsigned PROD_W      = DATA_W + SCALE_W;
  localparam int unsigned SCALE_FRAC  = 8;   // fraction bits of the time scale
  localparam int unsigned STEP_W      = 4;   // steps taken within one frame
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned DIV_CNT_W   = 6;

  localparam logic [STEP_W-1:0]    MAX_CATCHUP = STEP_W'(8);
  localparam logic [DIV_CNT_W-1:0] MOD_ITERS   = DIV_CNT_W'(DATA_W);
  localparam logic [DIV_CNT_W-1:0] FRAC_ITERS  = DIV_CNT_W'(FRAC_W);

  localparam logic [DATA_W-1:0]  RESET_FIXED_PERIOD   = DATA_W'(279620);
  localparam logic [SCALE_W-1:0] RESET_TIME_SCALE     = SCALE_W'(256);
  localparam logic [DATA_W-1:0]  RESET_MAX_FRAME_TIME = DATA_W'(1118481);

  localparam logic KIND_STEP      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_PERIOD   = 2'd0,
    REG_TIME_SCALE     = 2'd1,
    REG_MAX_FRAME_TIME = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    rem_init;
    logic [DATA_W-1:0]    dividend;
    logic [DATA_W-1:0]    divisor;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] remainder;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/ftp_if.sv */
// valid/ready channel interfaces of the fixed timestep pacer
// depends on ftp_pkg for field widths
interface ftp_in_if;
  import ftp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] real_delta;
  modport source (output valid, output real_delta, input ready);
  modport sink (input valid, input real_delta, output ready);
endinterface

interface ftp_out_if;
  import ftp_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] tick_count;
  logic [DATA_W-1:0] frame_count;
  logic [FRAC_W-1:0] blend_fraction;
  logic              catchup_dropped;
  logic              last;
  modport source (output valid, output kind, output tick_count, output frame_count,
                  output blend_fraction, output catchup_dropped, output last,
                  input ready);
  modport sink (input valid, input kind, input tick_count, input frame_count,
                input blend_fraction, input catchup_dropped, input last,
                output ready);
endinterface

interface ftp_cfg_if;
  import ftp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ftp_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on ftp_pkg for the request and response structs
module ftp_divider (
  input  logic             clk,
  input  logic             rst,
  input  ftp_pkg::div_req_t req,
  output ftp_pkg::div_rsp_t rsp
);
  import ftp_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dvd;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    divisor;

  // one trial subtract of the shifted partial remainder
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 fits;

  assign trial = {rem, dvd[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse once, right after the last iteration
      done <= !req.start && busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      dvd     <= req.dividend;
      divisor <= req.divisor;
      quo     <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;
  assign rsp.quotient  = quo;

endmodule

/* rtl/core/fixed_timestep_pacer.sv */
// fixed timestep pacer top level: config registers, sequencer and result register
// depends on ftp_pkg, the ftp interfaces and ftp_divider
//
// Each input item is one frame's real elapsed time in q8.24 seconds. The block
// scales it by time_scale (q8.8), saturates and clamps it to max_frame_time, adds
// it to a saturating accumulator, then emits one fixed step item per whole
// fixed_period removed, at most eight per frame, and closes the frame with a
// summary item (kind 1, last 1) that carries the frame count, the drop flag and
// the q0.16 blend fraction accumulator / period. A period of zero acts as one.
// The block works on one frame at a time: input ready is high only between
// frames. A frame passes through the multiply, scale and add states, then a check
// and an emit per step item (the emit waits while the sink stalls), the modulo
// when the catch-up limit is hit, the fraction division and the summary item.
// The next input item is accepted only after the summary item is loaded into
// the result register and the sequencer is back in idle. The modulo
// and the fraction share one restoring divider that produces one bit per cycle,
// and that divider sets most of the frame time. Configuration writes are taken
// at any time (ready is always high) and must only be issued between frames.
module fixed_timestep_pacer (
  input  logic             clk,
  input  logic             rst,
  ftp_cfg_if.sink          cfg,
  ftp_in_if.sink           in_item,
  ftp_out_if.source        out_item
);
  import ftp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_SCALE  = 9'b000000100,
    S_ADD    = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_MOD    = 9'b001000000,
    S_FRAC   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  // configuration registers
  logic [DATA_W-1:0]  fixed_period;
  logic [SCALE_W-1:0] time_scale;
  logic [DATA_W-1:0]  max_frame_time;

  // frame state
  logic [DATA_W-1:0]  time_accumulator;
  logic [DATA_W-1:0]  step_total;
  logic [DATA_W-1:0]  frame_total;
  logic [STEP_W-1:0]  steps_in_frame;

  // per frame working registers
  state_t             state;
  state_t             state_next;
  logic [DATA_W-1:0]  delta;
  logic [PROD_W-1:0]  product;
  logic [DATA_W-1:0]  scaled;
  logic [DATA_W-1:0]  period;
  logic               dropped;
  logic [FRAC_W-1:0]  blend;

  // result register
  logic               out_valid;
  logic               out_kind;
  logic [DATA_W-1:0]  out_ticks;
  logic [DATA_W-1:0]  out_frames;
  logic [FRAC_W-1:0]  out_blend;
  logic               out_drop;
  logic               out_last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_fire;
  logic               out_free;
  logic               emit;
  logic               whole_period;
  logic               at_limit;
  logic [DATA_W-1:0]  sat_scaled;
  logic [DATA_W:0]    acc_sum;

  assign cfg.ready     = 1'b1;
  assign in_item.ready = (state == S_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;

  // result register can take a new item when empty or being drained
  assign out_free = !out_valid || out_item.ready;
  assign emit     = out_free && ((state == S_STEP) || (state == S_FINISH));

  assign whole_period = time_accumulator >= period;
  assign at_limit     = steps_in_frame >= MAX_CATCHUP;

  // drop the q8.8 fraction, saturate to 32 bits, then clamp
  assign sat_scaled = (|product[PROD_W-1:DATA_W+SCALE_FRAC])
                      ? '1 : product[DATA_W+SCALE_FRAC-1:SCALE_FRAC];
  assign acc_sum    = {1'b0, time_accumulator} + {1'b0, scaled};

  // config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_period   <= RESET_FIXED_PERIOD;
      time_scale     <= RESET_TIME_SCALE;
      max_frame_time <= RESET_MAX_FRAME_TIME;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FIXED_PERIOD:   fixed_period   <= cfg.data;
        REG_TIME_SCALE:     time_scale     <= cfg.data[SCALE_W-1:0];
        REG_MAX_FRAME_TIME: max_frame_time <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) state_next = S_MUL;
      S_MUL:    state_next = S_SCALE;
      S_SCALE:  state_next = S_ADD;
      S_ADD:    state_next = S_CHECK;
      S_CHECK: begin
        if (!whole_period) state_next = S_FRAC;
        else if (at_limit) state_next = S_MOD;
        else               state_next = S_STEP;
      end
      S_STEP:   if (emit) state_next = S_CHECK;
      // after the modulo the accumulator is below the period, so check goes on to the fraction
      S_MOD:    if (div_rsp.done) state_next = S_CHECK;
      S_FRAC:   if (div_rsp.done) state_next = S_FINISH;
      S_FINISH: if (emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // divider start: modulo of the accumulator, or (accumulator << 16) / period
  always_comb begin
    div_req.start    = (state == S_CHECK) && (!whole_period || at_limit);
    div_req.divisor  = period;
    if (whole_period) begin
      div_req.rem_init = '0;
      div_req.dividend = time_accumulator;
      div_req.iters    = MOD_ITERS;
    end else begin
      div_req.rem_init = time_accumulator;
      div_req.dividend = '0;
      div_req.iters    = FRAC_ITERS;
    end
  end

  ftp_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      time_accumulator <= '0;
      step_total       <= '0;
      frame_total      <= '0;
      steps_in_frame   <= '0;
      dropped          <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ADD) begin
        time_accumulator <= acc_sum[DATA_W] ? '1 : acc_sum[DATA_W-1:0];
        steps_in_frame   <= '0;
        dropped          <= 1'b0;
      end
      if ((state == S_STEP) && emit) begin
        time_accumulator <= time_accumulator - period;
        step_total       <= step_total + DATA_W'(1);
        steps_in_frame   <= steps_in_frame + STEP_W'(1);
      end
      if ((state == S_MOD) && div_rsp.done) begin
        time_accumulator <= div_rsp.remainder;
        dropped          <= 1'b1;
      end
      if ((state == S_FINISH) && emit) begin
        frame_total <= frame_total + DATA_W'(1);
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta  <= in_item.real_delta;
      period <= (fixed_period == '0) ? DATA_W'(1) : fixed_period;
    end
    if (state == S_MUL) begin
      product <= {{SCALE_W{1'b0}}, delta} * {{DATA_W{1'b0}}, time_scale};
    end
    if (state == S_SCALE) begin
      scaled <= (sat_scaled > max_frame_time) ? max_frame_time : sat_scaled;
    end
    if ((state == S_FRAC) && div_rsp.done) begin
      blend <= div_rsp.quotient[FRAC_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == S_STEP) begin
        out_kind   <= KIND_STEP;
        out_ticks  <= step_total + DATA_W'(1);
        out_frames <= frame_total;
        out_blend  <= '0;
        out_drop   <= 1'b0;
        out_last   <= 1'b0;
      end else begin
        out_kind   <= KIND_FRAME_END;
        out_ticks  <= step_total;
        out_frames <= frame_total + DATA_W'(1);
        out_blend  <= blend;
        out_drop   <= dropped;
        out_last   <= 1'b1;
      end
    end
  end

  assign out_item.valid           = out_valid;
  assign out_item.kind            = out_kind;
  assign out_item.tick_count      = out_ticks;
  assign out_item.frame_count     = out_frames;
  assign out_item.blend_fraction  = out_blend;
  assign out_item.catchup_dropped = out_drop;
  assign out_item.last            = out_last;

endmodule
